// ===== design/scaled_glyph_line_renderer_assert.svh =====
// Assertion macros shared by the renderer modules.
`ifndef SCALED_GLYPH_LINE_RENDERER_ASSERT_SVH
`define SCALED_GLYPH_LINE_RENDERER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sglr_pkg.sv =====
package sglr_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_VISIBLE_COLS  = 2'd0;
	localparam logic [1:0] CFG_VISIBLE_LINES = 2'd1;
	localparam logic [1:0] CFG_LINE_PITCH    = 2'd2;
	localparam logic [1:0] CFG_PIXEL_FORMAT  = 2'd3;

	// Pixel format codes
	localparam logic [1:0] FMT_BGRX32 = 2'd0;
	localparam logic [1:0] FMT_BGR24  = 2'd1;
	localparam logic [1:0] FMT_RGB555 = 2'd2;

	// Reset values of the registers
	localparam logic [12:0] VISIBLE_COLS_RST  = 13'd1024;
	localparam logic [12:0] VISIBLE_LINES_RST = 13'd768;
	localparam logic [14:0] LINE_PITCH_RST    = 15'd4096;
	localparam logic [1:0]  PIXEL_FORMAT_RST  = FMT_BGRX32;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Four slots per font column: (line, pixel) pairs
	localparam int SLOT_COUNT = 32;

	typedef struct packed {
		logic [12:0] visible_cols;
		logic [12:0] visible_lines;
		logic [14:0] line_pitch;
		logic [1:0]  pixel_format;
	} cfg_t;

	// One classified glyph line waiting for the back end
	typedef struct packed {
		logic [SLOT_COUNT-1:0] mask;     // visible slots
		logic [7:0]            bits;
		logic [31:0]           fg_word;
		logic [31:0]           bg_word;
		logic [2:0]            bpp;
		logic [25:0]           row0_off; // offset of cell pixel 0 on first line
		logic [25:0]           row1_off; // same, one line lower
	} entry_t;

	// 16-color palette, index six is brown
	function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
		logic [23:0] rgb;
		case (idx)
			4'd0:    rgb = 24'h000000;
			4'd1:    rgb = 24'h0000AA;
			4'd2:    rgb = 24'h00AA00;
			4'd3:    rgb = 24'h00AAAA;
			4'd4:    rgb = 24'hAA0000;
			4'd5:    rgb = 24'hAA00AA;
			4'd6:    rgb = 24'hAA5500;
			4'd7:    rgb = 24'hAAAAAA;
			4'd8:    rgb = 24'h555555;
			4'd9:    rgb = 24'h5555FF;
			4'd10:   rgb = 24'h55FF55;
			4'd11:   rgb = 24'h55FFFF;
			4'd12:   rgb = 24'hFF5555;
			4'd13:   rgb = 24'hFF55FF;
			4'd14:   rgb = 24'hFFFF55;
			default: rgb = 24'hFFFFFF;
		endcase
		return rgb;
	endfunction

	function automatic logic [31:0] pack_pixel(input logic [23:0] rgb, input logic [1:0] fmt);
		logic [31:0] word;
		if (fmt == FMT_RGB555) begin
			word = {17'd0, rgb[23:19], rgb[15:11], rgb[7:3]};
		end else begin
			word = {8'd0, rgb};
		end
		return word;
	endfunction

	// Unknown format code falls back to 32 bpp
	function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
		logic [2:0] n;
		case (fmt)
			FMT_BGR24:  n = 3'd3;
			FMT_RGB555: n = 3'd2;
			default:    n = 3'd4;
		endcase
		return n;
	endfunction

	// Pixel column inside the 12-wide cell for a slot {dx, sy, sx}
	function automatic logic [3:0] slot_col(input logic [4:0] slot);
		logic [3:0] k;
		k = ({2'b0, slot[4:3]} << 1) + {2'b0, slot[4:3]} + {2'b0, slot[2], 1'b0}
			+ {3'b0, slot[0]};
		return k;
	endfunction

endpackage

// ===== design/sglr_front.sv =====
module sglr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         glyph_bits,
	input  logic [2:0]         glyph_line,
	input  logic [9:0]         cell_col,
	input  logic [9:0]         cell_row,
	input  logic [7:0]         color_attr,
	input  sglr_pkg::cfg_t     cfg,
	input  logic               queue_full,
	output logic               push,
	output sglr_pkg::entry_t   push_entry
);

	logic [3:0]                      line_off;
	logic [13:0]                     y0;
	logic [13:0]                     x0;
	logic [2:0]                      bpp;
	logic [15:0]                     x_base;
	logic [28:0]                     y_prod;
	logic [25:0]                     pitch_x;
	logic signed [14:0]              x_rem;
	logic signed [14:0]              y_rem;
	logic                            tall;
	logic [sglr_pkg::SLOT_COUNT-1:0] mask;
	logic                            adv;
	logic                            valid_s1;
	sglr_pkg::entry_t                entry_s1;
	sglr_pkg::entry_t                entry_d;

	// Cell origin: y = row*16 + line offset (offset < 16), x = col*12
	always_comb begin
		line_off = {1'b0, glyph_line[2], glyph_line[2], glyph_line[2]}
			+ {1'b0, glyph_line[1:0], 1'b0};
		y0       = {cell_row, line_off};
		x0       = {1'b0, cell_col, 3'b0} + {2'b0, cell_col, 2'b0};
		bpp      = sglr_pkg::bytes_per_pixel(cfg.pixel_format);
		case (bpp)
			3'd3:    x_base = {1'b0, x0, 1'b0} + {2'b0, x0};
			3'd2:    x_base = {1'b0, x0, 1'b0};
			default: x_base = {x0, 2'b0};
		endcase
		y_prod  = y0 * cfg.line_pitch;
		pitch_x = {11'd0, cfg.line_pitch} + {10'd0, x_base};
		tall    = (glyph_line[1:0] != 2'd3);
		x_rem   = signed'({2'b0, cfg.visible_cols}) - signed'({1'b0, x0});
		y_rem   = signed'({2'b0, cfg.visible_lines}) - signed'({1'b0, y0});
	end

	// Visible slots: slot exists in this column/line and lies on screen
	always_comb begin
		logic [4:0] sl;
		for (int s = 0; s < sglr_pkg::SLOT_COUNT; s++) begin
			sl = 5'(s);
			mask[s] = (!sl[0] || !sl[2]) && (!sl[1] || tall)
				&& (x_rem > signed'({11'd0, sglr_pkg::slot_col(sl)}))
				&& (y_rem > signed'({14'd0, sl[1]}));
		end
	end

	always_comb begin
		entry_d.mask     = mask;
		entry_d.bits     = glyph_bits;
		entry_d.fg_word  = sglr_pkg::pack_pixel(sglr_pkg::palette_rgb(color_attr[3:0]),
			cfg.pixel_format);
		entry_d.bg_word  = sglr_pkg::pack_pixel(sglr_pkg::palette_rgb(color_attr[7:4]),
			cfg.pixel_format);
		entry_d.bpp      = bpp;
		entry_d.row0_off = y_prod[25:0] + {10'd0, x_base};
		entry_d.row1_off = y_prod[25:0] + pitch_x;
	end

	// Stage moves when empty or when the queue takes its entry
	assign adv      = !valid_s1 || !queue_full;
	assign in_stall = !adv;
	assign push     = valid_s1;
	assign push_entry = entry_s1;

	// Fully clipped lines are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid && (mask != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

// ===== design/sglr_fifo.sv =====
module sglr_fifo #(
	parameter int DEPTH = sglr_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sglr_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output sglr_pkg::entry_t head,
	output logic             not_empty
);

`include "scaled_glyph_line_renderer_assert.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sglr_pkg::entry_t slots_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slots_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	`SGLR_ASSERT_NOW(a_fifo_level, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "queue over depth")
	`SGLR_ASSERT_NOW(a_fifo_pop_nonempty, clk, arst_n, pop, not_empty, "pop from empty queue")

endmodule

// ===== design/sglr_back.sv =====
module sglr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  sglr_pkg::entry_t q_entry,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [25:0]      byte_offset,
	output logic [31:0]      pixel_word,
	output logic [2:0]       byte_count,
	output logic             last_pixel
);

`include "scaled_glyph_line_renderer_assert.svh"

	sglr_pkg::entry_t                cur_q;
	logic [sglr_pkg::SLOT_COUNT-1:0] cur_mask_q;
	logic                            cur_busy;
	logic [4:0]                      slot;
	logic [sglr_pkg::SLOT_COUNT-1:0] mask_next;
	logic                            last_now;
	logic [3:0]                      col;
	logic [5:0]                      col_bytes;
	logic                            on;
	logic                            adv;
	logic                            emit;
	logic                            load;
	logic                            out_valid_q;
	logic [25:0]                     byte_offset_q;
	logic [31:0]                     pixel_word_q;
	logic [2:0]                      byte_count_q;
	logic                            last_pixel_q;

	// Lowest visible slot is the next pixel
	always_comb begin
		slot = '0;
		for (int i = sglr_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (cur_mask_q[i]) begin
				slot = 5'(i);
			end
		end
	end

	always_comb begin
		cur_busy  = (cur_mask_q != '0);
		mask_next = cur_mask_q & (cur_mask_q - 1'b1);
		last_now  = (mask_next == '0);
		col       = sglr_pkg::slot_col(slot);
		col_bytes = {2'b0, col} * {3'b0, cur_q.bpp};
		on        = cur_q.bits[~slot[4:2]];
	end

	// Handshake: output register frees, current entry emits, queue refills
	assign adv   = !out_valid_q || !out_stall;
	assign emit  = adv && cur_busy;
	assign load  = q_valid && (!cur_busy || (emit && last_now));
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_mask_q <= q_entry.mask;
			end else if (emit) begin
				cur_mask_q <= mask_next;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_entry;
		end
		if (emit) begin
			byte_offset_q <= (slot[1] ? cur_q.row1_off : cur_q.row0_off) + {20'd0, col_bytes};
			pixel_word_q  <= on ? cur_q.fg_word : cur_q.bg_word;
			byte_count_q  <= cur_q.bpp;
			last_pixel_q  <= last_now;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_offset = byte_offset_q;
	assign pixel_word  = pixel_word_q;
	assign byte_count  = byte_count_q;
	assign last_pixel  = last_pixel_q;

	`SGLR_ASSERT_NEXT(a_back_load_nonempty, clk, arst_n, load, cur_mask_q != '0, "empty entry loaded")
	`SGLR_ASSERT_NEXT(a_back_mid_pixel, clk, arst_n, emit && !last_now, out_valid_q && !last_pixel_q, "pixel ordering lost")

endmodule

// ===== design/scaled_glyph_line_renderer.sv =====
// Renders one 8-pixel font line into a 12x16 character cell, one pixel write per cycle
// while out_stall is low; a request gives one write per visible pixel (0 to 24), each
// through the single pixel-write register at the back end. A front stage clips and
// prices the line (row offset multiply, colors, visible-pixel mask) and hands it through
// a short queue, so the next request is taken while pixels are still going out. Fully
// clipped requests give no writes. The user must write registers on cfg_we only while
// the block is idle; the block itself does not enforce it.
module scaled_glyph_line_renderer #(
	parameter int QueueDepth = sglr_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  glyph_bits,
	input  logic [2:0]  glyph_line,
	input  logic [9:0]  cell_col,
	input  logic [9:0]  cell_row,
	input  logic [7:0]  color_attr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [25:0] byte_offset,
	output logic [31:0] pixel_word,
	output logic [2:0]  byte_count,
	output logic        last_pixel
);

	sglr_pkg::cfg_t   cfg_q;
	logic             queue_full;
	logic             push;
	sglr_pkg::entry_t push_entry;
	logic             pop;
	sglr_pkg::entry_t head;
	logic             not_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.visible_cols  <= sglr_pkg::VISIBLE_COLS_RST;
			cfg_q.visible_lines <= sglr_pkg::VISIBLE_LINES_RST;
			cfg_q.line_pitch    <= sglr_pkg::LINE_PITCH_RST;
			cfg_q.pixel_format  <= sglr_pkg::PIXEL_FORMAT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sglr_pkg::CFG_VISIBLE_COLS:  cfg_q.visible_cols  <= cfg_data[12:0];
				sglr_pkg::CFG_VISIBLE_LINES: cfg_q.visible_lines <= cfg_data[12:0];
				sglr_pkg::CFG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_data;
				sglr_pkg::CFG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	sglr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.glyph_bits (glyph_bits),
		.glyph_line (glyph_line),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.color_attr (color_attr),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	sglr_fifo #(
		.DEPTH (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty)
	);

	sglr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (not_empty),
		.q_entry     (head),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_offset (byte_offset),
		.pixel_word  (pixel_word),
		.byte_count  (byte_count),
		.last_pixel  (last_pixel)
	);

endmodule

// ===== test/tb_scaled_glyph_line_renderer.sv =====
module tb_scaled_glyph_line_renderer;

	// format code with no name in the package, decoded as 32 bpp
	localparam logic [1:0] FMT_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 10;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [7:0] bits;
		logic [2:0] line;
		logic [9:0] col;
		logic [9:0] row;
		logic [7:0] attr;
	} glyph_req_t;

	typedef struct packed {
		logic [25:0] offset;
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
	} pixel_write_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = sglr_pkg::CFG_VISIBLE_COLS;
	logic [14:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  glyph_bits = '0;
	logic [2:0]  glyph_line = '0;
	logic [9:0]  cell_col = '0;
	logic [9:0]  cell_row = '0;
	logic [7:0]  color_attr = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [25:0] byte_offset;
	logic [31:0] pixel_word;
	logic [2:0]  byte_count;
	logic        last_pixel;

	// shadow copy of the register file
	logic [12:0] scr_w = sglr_pkg::VISIBLE_COLS_RST;
	logic [12:0] scr_h = sglr_pkg::VISIBLE_LINES_RST;
	logic [14:0] pitch = sglr_pkg::LINE_PITCH_RST;
	logic [1:0]  fmt = sglr_pkg::PIXEL_FORMAT_RST;

	glyph_req_t   pending_reqs[$];
	pixel_write_t pixel_writes[$];

	int n_pushed = 0;
	int n_accepted = 0;
	int n_writes = 0;
	int n_errors = 0;
	int n_reg_writes = 0;
	int n_blocked = 0;
	int quiet_cycles = 0;
	bit req_taken = 1'b0;
	bit idle_on = 1'b1;
	bit held_once = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;

	scaled_glyph_line_renderer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.glyph_bits (glyph_bits),
		.glyph_line (glyph_line),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.color_attr (color_attr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.byte_offset(byte_offset),
		.pixel_word (pixel_word),
		.byte_count (byte_count),
		.last_pixel (last_pixel)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// standard 16-color text palette, entry six is brown
	function automatic logic [23:0] vga_rgb(input logic [3:0] idx);
		case (idx)
			4'h0: return 24'h000000;
			4'h1: return 24'h0000AA;
			4'h2: return 24'h00AA00;
			4'h3: return 24'h00AAAA;
			4'h4: return 24'hAA0000;
			4'h5: return 24'hAA00AA;
			4'h6: return 24'hAA5500;
			4'h7: return 24'hAAAAAA;
			4'h8: return 24'h555555;
			4'h9: return 24'h5555FF;
			4'hA: return 24'h55FF55;
			4'hB: return 24'h55FFFF;
			4'hC: return 24'hFF5555;
			4'hD: return 24'hFF55FF;
			4'hE: return 24'hFFFF55;
			default: return 24'hFFFFFF;
		endcase
	endfunction

	function automatic logic [31:0] color_word(input logic [3:0] idx, input logic [1:0] f);
		logic [23:0] rgb;
		rgb = vga_rgb(idx);
		if (f == sglr_pkg::FMT_RGB555)
			return {17'd0, rgb[23:19], rgb[15:11], rgb[7:3]};
		return {8'd0, rgb};
	endfunction

	function automatic logic [2:0] pixel_bytes(input logic [1:0] f);
		case (f)
			sglr_pkg::FMT_BGR24:  return 3'd3;
			sglr_pkg::FMT_RGB555: return 3'd2;
			default:              return 3'd4;
		endcase
	endfunction

	// Expand one font line into the cell and queue its visible pixel writes.
	// Order: font column, then cell line, then pixel within the column.
	function automatic void predict_glyph_line(input glyph_req_t r);
		logic [31:0] x0, y0, xs, x, y, ofs, fg, bg;
		logic [2:0] nb;
		int unsigned dx, sy, sx, height, span;
		pixel_write_t held;
		bit have;
		have = 1'b0;
		held = '0;
		nb = pixel_bytes(fmt);
		fg = color_word(r.attr[3:0], fmt);
		bg = color_word(r.attr[7:4], fmt);
		height = (r.line[1:0] != 2'd3) ? 2 : 1;
		x0 = 32'(r.col) * 12;
		y0 = 32'(r.row) * 16 + 32'(r.line[2]) * 7 + 32'(r.line[1:0]) * 2;
		for (dx = 0; dx < 8; dx++) begin
			span = dx[0] ? 1 : 2;
			xs = x0 + (dx >> 1) * 3 + (dx & 1) * 2;
			for (sy = 0; sy < height; sy++) begin
				y = y0 + sy;
				for (sx = 0; sx < span; sx++) begin
					x = xs + sx;
					if (x < 32'(scr_w) && y < 32'(scr_h)) begin
						// hold back one write so the final one can be marked
						if (have)
							pixel_writes.push_back(held);
						ofs = y * 32'(pitch) + x * 32'(nb);
						held.offset = ofs[25:0];
						held.word = r.bits[7 - dx] ? fg : bg;
						held.count = nb;
						held.last = 1'b0;
						have = 1'b1;
					end
				end
			end
		end
		if (have) begin
			held.last = 1'b1;
			pixel_writes.push_back(held);
		end
	endfunction

	// mostly short gaps, a few long ones, none while idling is off
	function automatic int pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// cell coordinate, usually inside the visible area
	function automatic logic [9:0] pick_cell(input int unsigned span);
		if ($urandom_range(0, 4) == 0)
			return 10'($urandom);
		return 10'($urandom_range(0, (span > 1023) ? 1023 : span));
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic push_req(input logic [7:0] bits, input logic [2:0] line,
			input logic [9:0] col, input logic [9:0] row, input logic [7:0] attr);
		glyph_req_t r;
		r.bits = bits;
		r.line = line;
		r.col = col;
		r.row = row;
		r.attr = attr;
		pending_reqs.push_back(r);
		n_pushed++;
	endtask

	task automatic push_random(input int count);
		logic [7:0] bits;
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			bits = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
			push_req(bits, 3'($urandom_range(0, 7)), pick_cell(32'(scr_w) / 12),
				pick_cell(32'(scr_h) / 16), 8'($urandom));
		end
	endtask

	// wait for every request and every pixel write, then for any clipped tail
	task automatic settle();
		while (n_accepted != n_pushed || pixel_writes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [14:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_reg_writes++;
		case (idx)
			sglr_pkg::CFG_VISIBLE_COLS:  scr_w = val[12:0];
			sglr_pkg::CFG_VISIBLE_LINES: scr_h = val[12:0];
			sglr_pkg::CFG_LINE_PITCH:    pitch = val;
			default:                     fmt = val[1:0];
		endcase
	endtask

	task automatic set_all(input logic [12:0] w, input logic [12:0] h,
			input logic [14:0] p, input logic [1:0] f);
		set_reg(sglr_pkg::CFG_VISIBLE_COLS, {2'b0, w});
		set_reg(sglr_pkg::CFG_VISIBLE_LINES, {2'b0, h});
		set_reg(sglr_pkg::CFG_LINE_PITCH, p);
		set_reg(sglr_pkg::CFG_PIXEL_FORMAT, {13'b0, f});
	endtask

	// request acceptance and prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			req_taken = 1'b1;
			n_accepted++;
			predict_glyph_line({glyph_bits, glyph_line, cell_col, cell_row, color_attr});
		end else begin
			req_taken = 1'b0;
		end
		if (arst_n && in_valid && in_stall)
			n_blocked++;
	end

	// request driver
	always @(negedge clk) begin : driver
		glyph_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				r = pending_reqs.pop_front();
				glyph_bits <= r.bits;
				glyph_line <= r.line;
				cell_col <= r.col;
				cell_row <= r.row;
				color_attr <= r.attr;
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off to back up the block
	always @(negedge clk) begin
		if (!held_once && n_accepted >= 40) begin
			hold_left = HOLD_CYCLES;
			held_once = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	// pixel write monitor
	always @(posedge clk) begin : monitor
		pixel_write_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_writes++;
			if (pixel_writes.size() == 0) begin
				report_mismatch($sformatf("pixel write at %h with nothing expected",
					byte_offset));
			end else begin
				want = pixel_writes.pop_front();
				if (byte_offset !== want.offset)
					report_mismatch($sformatf("byte_offset %h, expected %h",
						byte_offset, want.offset));
				if (pixel_word !== want.word)
					report_mismatch($sformatf("pixel_word %h, expected %h at offset %h",
						pixel_word, want.word, want.offset));
				if (byte_count !== want.count)
					report_mismatch($sformatf("byte_count %0d, expected %0d at offset %h",
						byte_count, want.count, want.offset));
				if (last_pixel !== want.last)
					report_mismatch($sformatf("last_pixel %b, expected %b at offset %h",
						last_pixel, want.last, want.offset));
			end
		end
	end

	// watchdog on cycles with no request and no pixel write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no progress for %0d cycles, %0d pixel writes outstanding",
					quiet_cycles, pixel_writes.size());
				$display("scaled_glyph_line_renderer: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int unsigned pick;
		logic [12:0] w, h;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed lines at the reset setting: solid, empty, every palette index and line
		idle_on = 1'b0;
		push_req(8'h00, 3'd0, 10'd0, 10'd0, 8'h0F);
		push_req(8'hFF, 3'd1, 10'd1, 10'd0, 8'hF0);
		for (i = 0; i < 16; i++)
			push_req(8'hA5 ^ 8'(i * 17), 3'(i), 10'(i), 10'(i), {4'(i), 4'(15 - i)});
		// partial clip at the right edge, a line in the bottom cell row, and fully off screen
		push_req(8'h81, 3'd7, 10'd85, 10'd0, 8'h6E);
		push_req(8'h3C, 3'd3, 10'd5, 10'd47, 8'h16);
		push_req(8'hFF, 3'd0, 10'd0, 10'd48, 8'h71);
		push_req(8'hFF, 3'd7, 10'd1023, 10'd1023, 8'hFF);
		settle();

		// 24 bpp on a large screen; the long receiver hold-off lands here
		idle_on = 1'b1;
		set_all(13'd4096, 13'd4096, 15'd16384, sglr_pkg::FMT_BGR24);
		push_random(30);
		settle();

		// 16 bpp with widest registers, offsets wrap past 26 bits
		set_all(13'd8191, 13'd8191, 15'd32767, sglr_pkg::FMT_RGB555);
		push_req(8'hF0, 3'd6, 10'd600, 10'd511, 8'h9C);
		push_random(30);
		settle();

		// zero width, then zero height: everything clipped
		set_reg(sglr_pkg::CFG_VISIBLE_COLS, 15'd0);
		push_random(5);
		settle();
		set_reg(sglr_pkg::CFG_VISIBLE_COLS, 15'd100);
		set_reg(sglr_pkg::CFG_VISIBLE_LINES, 15'd0);
		push_random(5);
		settle();

		// single-pixel screen with the unused format code
		set_all(13'd1, 13'd1, 15'd1, FMT_UNUSED);
		push_random(10);
		settle();

		// random settings, one phase without any idling
		for (i = 0; i < 5; i++) begin
			pick = $urandom_range(0, 3);
			w = (pick == 0) ? 13'd1024 : (pick == 1) ? 13'd8191 : 13'($urandom_range(1, 8191));
			pick = $urandom_range(0, 3);
			h = (pick == 0) ? 13'd768 : (pick == 1) ? 13'd8191 : 13'($urandom_range(1, 8191));
			idle_on = (i != 2);
			set_all(w, h, 15'($urandom_range(1, 32767)), 2'($urandom_range(0, 3)));
			push_random(22);
			settle();
		end

		repeat (20) @(negedge clk);
		if (pixel_writes.size() != 0)
			report_mismatch($sformatf("%0d expected pixel writes never arrived",
				pixel_writes.size()));
		$display("%0d glyph lines rendered into %0d pixel writes over %0d register writes",
			n_accepted, n_writes, n_reg_writes);
		$display("all three formats and the spare code, edge and full clipping, %s %0d cycles",
			"input blocked", n_blocked);
		if (n_errors == 0) begin
			$display("scaled_glyph_line_renderer: match");
		end else begin
			$display("scaled_glyph_line_renderer: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/sglr_pkg.sv
design/sglr_front.sv
design/sglr_fifo.sv
design/sglr_back.sv
design/scaled_glyph_line_renderer.sv
test/tb_scaled_glyph_line_renderer.sv
